@@ hw/rtl/bptc_pkg.sv @@
// Shared types and constants of the barometer compensation pipeline.
`default_nettype none

package bptc_pkg;

    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = 64 / DIV_BITS;

    localparam logic [20:0]        ADC_FULL    = 21'd1048576;
    localparam logic signed [26:0] OFFSET_FINE = 27'sd128000;
    localparam logic [15:0]        SCALE       = 16'd3125;
    localparam logic [24:0]        OUT_MAX     = 25'h1FF_FFFF;
    localparam int                 OFFSET_BIT  = 47;
    localparam int                 DEN_SHIFT   = 33;

    typedef enum logic [1:0] {
        REG_TEMP    = 2'd0,
        REG_PRESS_A = 2'd1,
        REG_PRESS_B = 2'd2,
        REG_PRESS_C = 2'd3
    } bptc_reg_t;

    typedef struct packed {
        logic [19:0] adc_temperature;
        logic [19:0] adc_pressure;
    } bptc_in_t;

    typedef struct packed {
        logic signed [15:0] temperature_centi;
        logic [24:0]        pressure_q24_8;
        logic               pressure_valid;
    } bptc_out_t;

    typedef struct packed {
        logic               neg;
        logic               zero;
        logic signed [15:0] temp;
    } bptc_side_t;

endpackage

`default_nettype wire

@@ hw/rtl/bptc_stream_if.sv @@
// Valid/ready stream interface carrying one payload per transaction.
`default_nettype none

interface bptc_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bptc_div.sv @@
// Pipelined restoring divider: 64-bit dividend by 31-bit divisor, several bits per stage.
`default_nettype none

module bptc_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [63:0]           dividend,
    input  logic [30:0]           divisor,
    input  bptc_pkg::bptc_side_t  in_side,
    output logic                  out_valid,
    output logic [63:0]           quotient,
    output bptc_pkg::bptc_side_t  out_side
);

    localparam int NS = bptc_pkg::DIV_STAGES;

    logic                 vld_reg  [NS];
    logic [63:0]          q_reg    [NS];
    logic [30:0]          rem_reg  [NS];
    logic [30:0]          md_reg   [NS];
    bptc_pkg::bptc_side_t side_reg [NS];

    logic                 src_vld  [NS];
    logic [63:0]          src_q    [NS];
    logic [30:0]          src_rem  [NS];
    logic [30:0]          src_md   [NS];
    bptc_pkg::bptc_side_t src_side [NS];
    logic [63:0]          q_next   [NS];
    logic [30:0]          rem_next [NS];

    for (genvar g = 0; g < NS; g++) begin : g_stage
        if (g == 0) begin : g_first
            assign src_vld[g]  = in_valid;
            assign src_q[g]    = dividend;
            assign src_rem[g]  = 31'd0;
            assign src_md[g]   = divisor;
            assign src_side[g] = in_side;
        end else begin : g_rest
            assign src_vld[g]  = vld_reg[g-1];
            assign src_q[g]    = q_reg[g-1];
            assign src_rem[g]  = rem_reg[g-1];
            assign src_md[g]   = md_reg[g-1];
            assign src_side[g] = side_reg[g-1];
        end

        always_comb
        begin
            logic [31:0] r2;
            logic [30:0] rem;
            logic [63:0] q;
            rem = src_rem[g];
            q   = src_q[g];
            for (int k = 0; k < bptc_pkg::DIV_BITS; k++)
            begin
                r2 = {rem, q[63]};
                q  = {q[62:0], 1'b0};
                if (r2 >= {1'b0, src_md[g]})
                begin
                    rem  = 31'(r2 - {1'b0, src_md[g]});
                    q[0] = 1'b1;
                end
                else
                begin
                    rem = r2[30:0];
                end
            end
            q_next[g]   = q;
            rem_next[g] = rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            for (int i = 0; i < NS; i++)
            begin
                vld_reg[i] <= src_vld[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NS; i++)
            begin
                q_reg[i]    <= q_next[i];
                rem_reg[i]  <= rem_next[i];
                md_reg[i]   <= src_md[i];
                side_reg[i] <= src_side[i];
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign quotient  = q_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

`default_nettype wire

@@ hw/rtl/baro_temp_pressure_compensation_top.sv @@
// Top level of the barometer temperature and pressure compensation pipeline.
// The samples channel takes one raw temperature and pressure pair per transaction;
// the results channel returns one compensated temperature and pressure per sample,
// in the order the samples arrived.
// Calibration words are loaded through cfg_we, cfg_index and cfg_data; the user must
// load them only while the pipeline is empty, as the block itself does not enforce it.
// Each write takes effect at the clock edge where cfg_we is high. Throughput is one
// transaction per cycle while the receiver does not stall. The result of a sample
// passes through eight arithmetic stages, sixteen stages of the divider at four
// quotient bits each, four correction stages and the output register.
// When the receiver stalls with a result held, the whole pipeline holds and
// samples.ready drops; nothing is lost or repeated, and bubbles stay in place.
// Reset clears the calibration registers and all stage valid bits.
`default_nettype none

module baro_temp_pressure_compensation_top (
    input  logic                  clk,
    input  logic                  rst_n,
    bptc_stream_if.sink           samples,
    bptc_stream_if.source         results,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [47:0]           cfg_data
);

    function automatic logic [63:0] mul_lo64(input logic [63:0] a, input logic [15:0] b,
                                             input logic b_signed);
        logic [47:0] pl;
        logic [47:0] ph;
        logic [63:0] corr;
        pl   = a[31:0] * b;
        ph   = a[63:32] * b;
        corr = (b_signed && b[15]) ? {a[47:0], 16'b0} : 64'b0;
        return {16'b0, pl} + {ph[31:0], 32'b0} - corr;
    endfunction

    logic [47:0] temp_coeffs_reg;
    logic [47:0] press_a_reg;
    logic [47:0] press_b_reg;
    logic [47:0] press_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= 48'd0;
            press_a_reg     <= 48'd0;
            press_b_reg     <= 48'd0;
            press_c_reg     <= 48'd0;
        end
        else if (cfg_we)
        begin
            unique case (bptc_pkg::bptc_reg_t'(cfg_index))
                bptc_pkg::REG_TEMP:    temp_coeffs_reg <= cfg_data;
                bptc_pkg::REG_PRESS_A: press_a_reg     <= cfg_data;
                bptc_pkg::REG_PRESS_B: press_b_reg     <= cfg_data;
                bptc_pkg::REG_PRESS_C: press_c_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p7;

    assign t1 = temp_coeffs_reg[15:0];
    assign t2 = $signed(temp_coeffs_reg[31:16]);
    assign t3 = $signed(temp_coeffs_reg[47:32]);
    assign p1 = press_a_reg[15:0];
    assign p2 = $signed(press_a_reg[31:16]);
    assign p4 = $signed(press_b_reg[15:0]);
    assign p5 = $signed(press_b_reg[31:16]);
    assign p7 = $signed(press_c_reg[15:0]);

    logic adv;
    logic out_valid_reg;
    bptc_pkg::bptc_out_t out_payload_reg;

    assign adv           = !out_valid_reg || results.ready;
    assign samples.ready = adv;

    // Temperature and pressure arithmetic stages.
    logic               s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic               s5_vld_reg, s6_vld_reg, s7_vld_reg, s8_vld_reg;
    logic signed [33:0] s1_ma_reg;
    logic signed [33:0] s1_sq_reg;
    logic [19:0]        s1_adcp_reg, s2_adcp_reg, s3_adcp_reg, s4_adcp_reg, s5_adcp_reg;
    logic signed [22:0] s2_a_reg;
    logic signed [37:0] s2_mb_reg;
    logic signed [15:0] s3_temp_reg, s4_temp_reg, s5_temp_reg, s6_temp_reg, s7_temp_reg;
    logic signed [26:0] s3_v1_reg;
    logic signed [53:0] s4_vsq_reg;
    logic signed [42:0] s4_m5_reg, s4_m2_reg, s5_m5_reg, s5_m2_reg;
    logic [63:0]        s5_x6_reg, s5_x3_reg;
    logic [63:0]        s6_t_reg, s6_num0_reg;
    logic [63:0]        s7_den_reg, s7_num_reg;
    logic [63:0]        s8_mn_reg;
    logic [30:0]        s8_md_reg;
    bptc_pkg::bptc_side_t s8_side_reg;

    logic signed [17:0] d1;
    logic signed [16:0] d2;
    logic signed [25:0] fine;
    logic signed [28:0] t5;
    logic signed [20:0] t8;
    logic signed [15:0] temp_sat;
    logic [63:0]        v2;
    logic [63:0]        v1b;
    logic [20:0]        padc;
    logic signed [30:0] den;

    always_comb
    begin
        d1   = $signed({1'b0, samples.payload.adc_temperature[19:3]})
             - $signed({1'b0, t1, 1'b0});
        d2   = $signed({1'b0, samples.payload.adc_temperature[19:4]}) - $signed({1'b0, t1});
        fine = 26'(s2_a_reg) + 26'(s2_mb_reg >>> 14);
        t5   = (29'(fine) <<< 2) + 29'(fine) + 29'sd128;
        t8   = 21'(t5 >>> 8);
        if (t8 > 21'sd32767)
        begin
            temp_sat = 16'sh7FFF;
        end
        else if (t8 < -21'sd32768)
        begin
            temp_sat = 16'sh8000;
        end
        else
        begin
            temp_sat = 16'(t8);
        end
        v2   = s5_x6_reg + (64'(s5_m5_reg) << 17) + (64'(p4) << 35);
        v1b  = 64'($signed(s5_x3_reg) >>> 8) + (64'(s5_m2_reg) << 12);
        padc = bptc_pkg::ADC_FULL - {1'b0, s5_adcp_reg};
        den  = $signed(s7_den_reg[63:bptc_pkg::DEN_SHIFT]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            s8_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= samples.valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
            s8_vld_reg <= s7_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ma_reg   <= d1 * t2;
            s1_sq_reg   <= d2 * d2;
            s1_adcp_reg <= samples.payload.adc_pressure;

            s2_a_reg    <= 23'(s1_ma_reg >>> 11);
            s2_mb_reg   <= 22'(s1_sq_reg >>> 12) * t3;
            s2_adcp_reg <= s1_adcp_reg;

            s3_temp_reg <= temp_sat;
            s3_v1_reg   <= 27'(fine) - bptc_pkg::OFFSET_FINE;
            s3_adcp_reg <= s2_adcp_reg;

            s4_vsq_reg  <= s3_v1_reg * s3_v1_reg;
            s4_m5_reg   <= s3_v1_reg * p5;
            s4_m2_reg   <= s3_v1_reg * p2;
            s4_temp_reg <= s3_temp_reg;
            s4_adcp_reg <= s3_adcp_reg;

            s5_x6_reg   <= mul_lo64(64'(s4_vsq_reg), press_b_reg[47:32], 1'b1);
            s5_x3_reg   <= mul_lo64(64'(s4_vsq_reg), press_a_reg[47:32], 1'b1);
            s5_m5_reg   <= s4_m5_reg;
            s5_m2_reg   <= s4_m2_reg;
            s5_temp_reg <= s4_temp_reg;
            s5_adcp_reg <= s4_adcp_reg;

            s6_t_reg    <= v1b + (64'd1 << bptc_pkg::OFFSET_BIT);
            s6_num0_reg <= {12'b0, padc, 31'b0} - v2;
            s6_temp_reg <= s5_temp_reg;

            s7_den_reg  <= mul_lo64(s6_t_reg, p1, 1'b0);
            s7_num_reg  <= mul_lo64(s6_num0_reg, bptc_pkg::SCALE, 1'b0);
            s7_temp_reg <= s6_temp_reg;

            s8_mn_reg        <= s7_num_reg[63] ? (64'd0 - s7_num_reg) : s7_num_reg;
            s8_md_reg        <= den[30] ? (31'd0 - den) : den;
            s8_side_reg.neg  <= s7_num_reg[63] ^ den[30];
            s8_side_reg.zero <= (den == 31'sd0);
            s8_side_reg.temp <= s7_temp_reg;
        end
    end

    logic                 div_valid;
    logic [63:0]          div_q;
    bptc_pkg::bptc_side_t div_side;

    bptc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s8_vld_reg),
        .dividend  (s8_mn_reg),
        .divisor   (s8_md_reg),
        .in_side   (s8_side_reg),
        .out_valid (div_valid),
        .quotient  (div_q),
        .out_side  (div_side)
    );

    // Pressure correction stages after the divider.
    logic               sa_vld_reg, sb_vld_reg, sc_vld_reg, sd_vld_reg;
    logic [63:0]        sa_p_reg, sb_p_reg, sc_p_reg, sd_p_reg;
    logic [63:0]        sb_ll_reg;
    logic [31:0]        sb_hl_reg;
    logic [63:0]        sb_m8_reg;
    logic [63:0]        sc_sq_reg;
    logic [63:0]        sc_c2_reg, sd_c2_reg;
    logic [63:0]        sd_m9_reg;
    logic               sa_zero_reg, sb_zero_reg, sc_zero_reg, sd_zero_reg;
    logic signed [15:0] sa_temp_reg, sb_temp_reg, sc_temp_reg, sd_temp_reg;

    logic [63:0]        ps;
    logic [63:0]        psum;
    logic [63:0]        pres;
    logic [24:0]        press_sat;
    bptc_pkg::bptc_out_t out_next;

    always_comb
    begin
        ps   = 64'($signed(sa_p_reg) >>> 13);
        psum = sd_p_reg + 64'($signed(sd_m9_reg) >>> 25) + sd_c2_reg;
        pres = 64'($signed(psum) >>> 8) + (64'(p7) << 4);
        if (pres[63])
        begin
            press_sat = 25'd0;
        end
        else if (pres > 64'(bptc_pkg::OUT_MAX))
        begin
            press_sat = bptc_pkg::OUT_MAX;
        end
        else
        begin
            press_sat = pres[24:0];
        end
        out_next.temperature_centi = sd_temp_reg;
        out_next.pressure_q24_8    = sd_zero_reg ? 25'd0 : press_sat;
        out_next.pressure_valid    = !sd_zero_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_vld_reg    <= 1'b0;
            sb_vld_reg    <= 1'b0;
            sc_vld_reg    <= 1'b0;
            sd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sa_vld_reg    <= div_valid;
            sb_vld_reg    <= sa_vld_reg;
            sc_vld_reg    <= sb_vld_reg;
            sd_vld_reg    <= sc_vld_reg;
            out_valid_reg <= sd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_p_reg    <= div_side.neg ? (64'd0 - div_q) : div_q;
            sa_zero_reg <= div_side.zero;
            sa_temp_reg <= div_side.temp;

            sb_ll_reg   <= ps[31:0] * ps[31:0];
            sb_hl_reg   <= ps[63:32] * ps[31:0];
            sb_m8_reg   <= mul_lo64(sa_p_reg, press_c_reg[31:16], 1'b1);
            sb_p_reg    <= sa_p_reg;
            sb_zero_reg <= sa_zero_reg;
            sb_temp_reg <= sa_temp_reg;

            sc_sq_reg   <= sb_ll_reg + {sb_hl_reg[30:0], 33'b0};
            sc_c2_reg   <= 64'($signed(sb_m8_reg) >>> 19);
            sc_p_reg    <= sb_p_reg;
            sc_zero_reg <= sb_zero_reg;
            sc_temp_reg <= sb_temp_reg;

            sd_m9_reg   <= mul_lo64(sc_sq_reg, press_c_reg[47:32], 1'b1);
            sd_c2_reg   <= sc_c2_reg;
            sd_p_reg    <= sc_p_reg;
            sd_zero_reg <= sc_zero_reg;
            sd_temp_reg <= sc_temp_reg;

            out_payload_reg <= out_next;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = out_payload_reg;

endmodule

`default_nettype wire

@@ tb/bptc_checker.sv @@
// Checker that predicts compensated results from observed samples and compares them.
`timescale 1ns / 100ps
`default_nettype none

module bptc_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  bptc_pkg::bptc_in_t   in_payload,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  bptc_pkg::bptc_out_t  out_payload,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [47:0]          cfg_data,
    output int                   errors,
    output int                   pending
);

    logic [47:0]         coef_t;
    logic [47:0]         coef_a;
    logic [47:0]         coef_b;
    logic [47:0]         coef_c;
    bptc_pkg::bptc_out_t expected_q[$];

    function automatic logic signed [63:0] sx(input logic [47:0] r, input int sh);
        logic signed [15:0] w;
        begin
            w = r[sh +: 16];
            return 64'(w);
        end
    endfunction

    function automatic bptc_pkg::bptc_out_t compensate(input bptc_pkg::bptc_in_t s);
        logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] d1, d2, fine, tc, v1, v2, p, ps, c1, c2, num, mn, md;
        logic [63:0]        q;
        logic               neg;
        bptc_pkg::bptc_out_t r;
        begin
            t1 = {48'd0, coef_t[15:0]};
            t2 = sx(coef_t, 16);
            t3 = sx(coef_t, 32);
            p1 = {48'd0, coef_a[15:0]};
            p2 = sx(coef_a, 16);
            p3 = sx(coef_a, 32);
            p4 = sx(coef_b, 0);
            p5 = sx(coef_b, 16);
            p6 = sx(coef_b, 32);
            p7 = sx(coef_c, 0);
            p8 = sx(coef_c, 16);
            p9 = sx(coef_c, 32);
            d1 = $signed({44'd0, s.adc_temperature} >> 3) - (t1 <<< 1);
            d2 = $signed({44'd0, s.adc_temperature} >> 4) - t1;
            fine = ((d1 * t2) >>> 11) + ((((d2 * d2) >>> 12) * t3) >>> 14);
            tc = (fine * 5 + 128) >>> 8;
            if (tc > 32767)
                tc = 32767;
            if (tc < -32768)
                tc = -32768;
            r.temperature_centi = tc[15:0];
            v1 = fine - 64'sd128000;
            v2 = v1 * v1 * p6 + ((v1 * p5) <<< 17) + (p4 <<< 35);
            v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
            v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
            r.pressure_q24_8 = '0;
            r.pressure_valid = 1'b0;
            if (v1 != 0)
            begin
                p = 64'sd1048576 - $signed({44'd0, s.adc_pressure});
                num = ((p <<< 31) - v2) * 64'sd3125;
                neg = num[63] ^ v1[63];
                mn = num[63] ? -num : num;
                md = v1[63] ? -v1 : v1;
                q = $unsigned(mn) / $unsigned(md);
                p = neg ? -$signed(q) : $signed(q);
                ps = p >>> 13;
                c1 = (p9 * ps * ps) >>> 25;
                c2 = (p8 * p) >>> 19;
                p = ((p + c1 + c2) >>> 8) + (p7 <<< 4);
                if (p < 0)
                    r.pressure_q24_8 = '0;
                else if (p > 64'sd33554431)
                    r.pressure_q24_8 = bptc_pkg::OUT_MAX;
                else
                    r.pressure_q24_8 = p[24:0];
                r.pressure_valid = 1'b1;
            end
            return r;
        end
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        int bad;
        bad = 0;
        if (!rst_n)
        begin
            coef_t <= '0;
            coef_a <= '0;
            coef_b <= '0;
            coef_c <= '0;
            errors <= 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (bptc_pkg::bptc_reg_t'(cfg_index))
                    bptc_pkg::REG_TEMP:    coef_t <= cfg_data;
                    bptc_pkg::REG_PRESS_A: coef_a <= cfg_data;
                    bptc_pkg::REG_PRESS_B: coef_b <= cfg_data;
                    bptc_pkg::REG_PRESS_C: coef_c <= cfg_data;
                endcase
            end
            if (in_valid && in_ready)
                expected_q.push_back(compensate(in_payload));
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, out_payload);
                    bad = bad + 1;
                end
                else
                begin
                    if (out_payload.temperature_centi !== expected_q[0].temperature_centi)
                    begin
                        $display("%0t: temperature expected %0d actual %0d", $time,
                                 expected_q[0].temperature_centi,
                                 out_payload.temperature_centi);
                        bad = bad + 1;
                    end
                    if (out_payload.pressure_q24_8 !== expected_q[0].pressure_q24_8)
                    begin
                        $display("%0t: pressure expected %0d actual %0d", $time,
                                 expected_q[0].pressure_q24_8, out_payload.pressure_q24_8);
                        bad = bad + 1;
                    end
                    if (out_payload.pressure_valid !== expected_q[0].pressure_valid)
                    begin
                        $display("%0t: valid expected %0b actual %0b", $time,
                                 expected_q[0].pressure_valid, out_payload.pressure_valid);
                        bad = bad + 1;
                    end
                    void'(expected_q.pop_front());
                end
            end
            errors <= errors + bad;
        end
    end

endmodule

`default_nettype wire

@@ tb/baro_temp_pressure_compensation_top_test.sv @@
// Testbench top that drives samples and calibration and reports the verdict.
`timescale 1ns / 100ps
`default_nettype none

module baro_temp_pressure_compensation_top_test;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;
    logic        quiet = 1'b0;
    int          errors;
    int          pending;

    bptc_stream_if #(.payload_t(bptc_pkg::bptc_in_t))  samples();
    bptc_stream_if #(.payload_t(bptc_pkg::bptc_out_t)) results();

    baro_temp_pressure_compensation_top uut (
        .clk(clk), .rst_n(rst_n), .samples(samples.sink), .results(results.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    bptc_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(samples.valid), .in_ready(samples.ready), .in_payload(samples.payload),
        .out_valid(results.valid), .out_ready(results.ready),
        .out_payload(results.payload),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        int stall;
        stall = 0;
        results.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall = stall - 1;
                results.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(0, 2);
                results.ready <= 1'b0;
            end
            else
                results.ready <= 1'b1;
        end
    end

    task automatic send_sample(input logic [19:0] t, input logic [19:0] p);
        int gap;
        begin
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 3);
                samples.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            samples.valid <= 1'b1;
            samples.payload <= '{adc_temperature: t, adc_pressure: p};
            @(posedge clk);
            while (!samples.ready)
                @(posedge clk);
        end
    endtask

    task automatic drain;
        begin
            samples.valid <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
            repeat (30) @(posedge clk);
        end
    endtask

    task automatic load_coeffs(input logic [47:0] c0, input logic [47:0] c1,
                               input logic [47:0] c2, input logic [47:0] c3);
        logic [47:0] vals[4];
        begin
            vals = '{c0, c1, c2, c3};
            for (int i = 0; i < 4; i++)
            begin
                cfg_we <= 1'b1;
                cfg_index <= i[1:0];
                cfg_data <= vals[i];
                @(posedge clk);
            end
            cfg_we <= 1'b0;
            @(posedge clk);
        end
    endtask

    function automatic logic [47:0] pack3(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] c);
        return {c, b, a};
    endfunction

    function automatic logic [47:0] jitter(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] c);
        return pack3(a + 16'($urandom_range(0, 200)) - 16'd100,
                     b + 16'($urandom_range(0, 200)) - 16'd100,
                     c + 16'($urandom_range(0, 20)) - 16'd10);
    endfunction

    initial
    begin
        logic [47:0] typ_t, typ_a, typ_b, typ_c;
        samples.valid = 1'b0;
        samples.payload = '0;
        typ_t = pack3(16'd27504, 16'd26435, -16'sd1000);
        typ_a = pack3(16'd36477, -16'sd10685, 16'd3024);
        typ_b = pack3(16'd2855, 16'd140, -16'sd7);
        typ_c = pack3(16'd15500, -16'sd14600, 16'd6000);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With all coefficients at reset the divisor is zero.
        send_sample(20'd0, 20'd0);
        send_sample(20'hFFFFF, 20'hFFFFF);
        drain();

        load_coeffs(typ_t, typ_a, typ_b, typ_c);
        send_sample(20'd519888, 20'd415148);
        send_sample(20'd0, 20'd0);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'd0, 20'hFFFFF);
        send_sample(20'hFFFFF, 20'd0);
        send_sample(20'h80000, 20'h80000);
        send_sample(20'h55555, 20'hAAAAA);
        send_sample(20'hAAAAA, 20'h55555);
        drain();

        load_coeffs('1, '1, '1, '1);
        send_sample(20'd0, 20'd0);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'h12345, 20'hFEDCB);
        drain();

        load_coeffs(pack3(16'hFFFF, 16'h7FFF, 16'h7FFF), pack3(16'h0, 16'h8000, 16'h8000),
                    pack3(16'h7FFF, 16'h8000, 16'h7FFF), pack3(16'h8000, 16'h7FFF, 16'h8000));
        send_sample(20'd0, 20'd0);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'h00FFF, 20'hFF000);
        drain();

        for (int phase = 0; phase < 11; phase++)
        begin
            if (phase % 4 == 3)
                load_coeffs(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                            48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
            else
                load_coeffs(jitter(typ_t[15:0], typ_t[31:16], typ_t[47:32]),
                            jitter(typ_a[15:0], typ_a[31:16], typ_a[47:32]),
                            jitter(typ_b[15:0], typ_b[31:16], typ_b[47:32]),
                            jitter(typ_c[15:0], typ_c[31:16], typ_c[47:32]));
            quiet = (phase == 10);
            for (int n = 0; n < 50; n++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_sample(20'($urandom), 20'($urandom));
                else
                    send_sample(20'($urandom_range(400000, 620000)),
                                20'($urandom_range(200000, 700000)));
            end
            drain();
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
